// ===== rtl/core/sgi_pkg.sv =====
// ----------------------------------------------------------------------------
// sgi_pkg
// Shared payload types and constants for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package sgi_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FIELD_BITS     = 16;
  localparam int RES_BITS       = 32;
  localparam int NUM_COORDS     = 8;
  localparam int QUOT_BITS      = 32;

  localparam logic signed [RES_BITS-1:0] RES_MAX = {1'b0, {(RES_BITS-1){1'b1}}};
  localparam logic signed [RES_BITS-1:0] RES_MIN = {1'b1, {(RES_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] seg1_start_x;
    logic signed [FIELD_BITS-1:0] seg1_start_y;
    logic signed [FIELD_BITS-1:0] seg1_end_x;
    logic signed [FIELD_BITS-1:0] seg1_end_y;
    logic signed [FIELD_BITS-1:0] seg2_start_x;
    logic signed [FIELD_BITS-1:0] seg2_start_y;
    logic signed [FIELD_BITS-1:0] seg2_end_x;
    logic signed [FIELD_BITS-1:0] seg2_end_y;
  } sgi_in_t;

  typedef struct packed {
    logic                       lines_cross;
    logic                       segments_hit;
    logic signed [RES_BITS-1:0] cross_x;
    logic signed [RES_BITS-1:0] cross_y;
  } sgi_out_t;

  // sign and overflow flags that travel beside the quotient magnitudes
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic ovf_x;
    logic ovf_y;
    logic par;
  } sgi_flags_t;

endpackage

// ===== rtl/core/sgi_front.sv =====
// ----------------------------------------------------------------------------
// sgi_front
// Line equations, determinant and Cramer numerators in five register stages;
// hands on magnitudes and signs for the divider.
// ----------------------------------------------------------------------------
module sgi_front import sgi_pkg::*; #(
  parameter int W = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sgi_in_t              pair,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3*W+3:0]       nmag_x,
  output logic [3*W+3:0]       nmag_y,
  output logic [2*W+2:0]       dmag,
  output sgi_flags_t           flags,
  output logic [8*W-1:0]       crd
);

  localparam int AW  = W + 1;
  localparam int PW  = 2 * W + 1;
  localparam int CW  = 2 * W + 2;
  localparam int DTW = 2 * W + 3;
  localparam int MW  = 3 * W + 3;
  localparam int NW  = 3 * W + 4;

  logic v1, v2, v3, v4, v5;
  logic r1, r2, r3, r4, r5;

  logic signed [W-1:0]  crd_in [NUM_COORDS];
  logic signed [W-1:0]  crd1 [NUM_COORDS];
  logic signed [W-1:0]  crd2 [NUM_COORDS];
  logic signed [W-1:0]  crd3 [NUM_COORDS];
  logic signed [W-1:0]  crd4 [NUM_COORDS];
  logic signed [W-1:0]  crd5 [NUM_COORDS];

  logic signed [AW-1:0] a1_s1, b1_s1, a2_s1, b2_s1;
  logic signed [AW-1:0] a1_s2, b1_s2, a2_s2, b2_s2;
  logic signed [AW-1:0] a1_s3, b1_s3, a2_s3, b2_s3;
  logic signed [PW-1:0] pa1, pb1, pa2, pb2;
  logic signed [CW-1:0] dl, dr;
  logic signed [CW-1:0] cc1, cc2;
  logic signed [DTW-1:0] det3, det4;
  logic signed [MW-1:0] m1, m2, m3, m4;
  logic signed [NW-1:0] nx, ny;
  logic [NW-1:0]        nmx, nmy;
  logic [DTW-1:0]       dm;
  sgi_flags_t           fl5;

  assign r5 = !v5 || out_ready;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  assign crd_in[0] = $signed(pair.seg1_start_x[W-1:0]);
  assign crd_in[1] = $signed(pair.seg1_start_y[W-1:0]);
  assign crd_in[2] = $signed(pair.seg1_end_x[W-1:0]);
  assign crd_in[3] = $signed(pair.seg1_end_y[W-1:0]);
  assign crd_in[4] = $signed(pair.seg2_start_x[W-1:0]);
  assign crd_in[5] = $signed(pair.seg2_start_y[W-1:0]);
  assign crd_in[6] = $signed(pair.seg2_end_x[W-1:0]);
  assign crd_in[7] = $signed(pair.seg2_end_y[W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
    end
  end

  // stage 1: line coefficients A and B
  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      crd1  <= crd_in;
      a1_s1 <= AW'(crd_in[3]) - AW'(crd_in[1]);
      b1_s1 <= AW'(crd_in[0]) - AW'(crd_in[2]);
      a2_s1 <= AW'(crd_in[7]) - AW'(crd_in[5]);
      b2_s1 <= AW'(crd_in[4]) - AW'(crd_in[6]);
    end
  end

  // stage 2: partial products of C and the determinant
  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      crd2  <= crd1;
      a1_s2 <= a1_s1;
      b1_s2 <= b1_s1;
      a2_s2 <= a2_s1;
      b2_s2 <= b2_s1;
      pa1   <= PW'(crd1[0]) * PW'(a1_s1);
      pb1   <= PW'(crd1[1]) * PW'(b1_s1);
      pa2   <= PW'(crd1[4]) * PW'(a2_s1);
      pb2   <= PW'(crd1[5]) * PW'(b2_s1);
      dl    <= CW'(a1_s1) * CW'(b2_s1);
      dr    <= CW'(a2_s1) * CW'(b1_s1);
    end
  end

  // stage 3: C and det
  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      crd3  <= crd2;
      a1_s3 <= a1_s2;
      b1_s3 <= b1_s2;
      a2_s3 <= a2_s2;
      b2_s3 <= b2_s2;
      cc1   <= CW'(pa1) + CW'(pb1);
      cc2   <= CW'(pa2) + CW'(pb2);
      det3  <= DTW'(dl) - DTW'(dr);
    end
  end

  // stage 4: numerator products
  always_ff @(posedge clk) begin
    if (r4 && v3) begin
      crd4 <= crd3;
      det4 <= det3;
      m1   <= MW'(cc1) * MW'(b2_s3);
      m2   <= MW'(cc2) * MW'(b1_s3);
      m3   <= MW'(cc2) * MW'(a1_s3);
      m4   <= MW'(cc1) * MW'(a2_s3);
    end
  end

  assign nx = NW'(m1) - NW'(m2);
  assign ny = NW'(m3) - NW'(m4);

  // stage 5: magnitudes and quotient signs
  always_ff @(posedge clk) begin
    if (r5 && v4) begin
      crd5      <= crd4;
      nmx       <= nx[NW-1] ? NW'(-nx) : NW'(nx);
      nmy       <= ny[NW-1] ? NW'(-ny) : NW'(ny);
      dm        <= det4[DTW-1] ? DTW'(-det4) : DTW'(det4);
      fl5.neg_x <= nx[NW-1] ^ det4[DTW-1];
      fl5.neg_y <= ny[NW-1] ^ det4[DTW-1];
      fl5.ovf_x <= 1'b0;
      fl5.ovf_y <= 1'b0;
      fl5.par   <= (det4 == '0);
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_COORDS; k++) begin
      crd[k*W +: W] = crd5[k];
    end
  end

  assign out_valid = v5;
  assign nmag_x    = nmx;
  assign nmag_y    = nmy;
  assign dmag      = dm;
  assign flags     = fl5;

endmodule

// ===== rtl/core/sgi_div.sv =====
// ----------------------------------------------------------------------------
// sgi_div
// Pipelined restoring divider, two lanes (x and y) sharing one divisor:
// an overflow check stage, then one quotient bit per stage.
// ----------------------------------------------------------------------------
module sgi_div import sgi_pkg::*; #(
  parameter int W = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3*W+3:0]       nmag_x,
  input  logic [3*W+3:0]       nmag_y,
  input  logic [2*W+2:0]       dmag,
  input  sgi_flags_t           flags_in,
  input  logic [8*W-1:0]       crd_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [QUOT_BITS-1:0] qmag_x,
  output logic [QUOT_BITS-1:0] qmag_y,
  output sgi_flags_t           flags,
  output logic [8*W-1:0]       crd
);

  localparam int NW = 3 * W + 4;
  localparam int DW = 2 * W + 3;
  localparam int LW = (NW > DW + QUOT_BITS) ? NW : DW + QUOT_BITS;
  localparam int NS = QUOT_BITS + 1;

  typedef struct packed {
    logic [DW-1:0]        rx;
    logic [DW-1:0]        ry;
    logic [QUOT_BITS-1:0] nlx;
    logic [QUOT_BITS-1:0] nly;
    logic [QUOT_BITS-1:0] qx;
    logic [QUOT_BITS-1:0] qy;
    logic [DW-1:0]        d;
    sgi_flags_t           fl;
    logic [8*W-1:0]       crd;
  } div_stage_t;

  typedef struct packed {
    logic [DW-1:0]        r;
    logic [QUOT_BITS-1:0] nl;
    logic [QUOT_BITS-1:0] q;
  } lane_t;

  logic       v       [NS];
  logic       rdy     [NS];
  div_stage_t st      [NS];
  div_stage_t st_next [NS];
  div_stage_t entry;
  lane_t      lx  [NS-1];
  lane_t      ly  [NS-1];
  logic [LW-1:0] dshift;

  function automatic lane_t div_step(lane_t cur, logic [DW-1:0] d);
    logic [DW:0] t;
    lane_t       nxt;
    t = {cur.r, cur.nl[QUOT_BITS-1]};
    nxt.nl = {cur.nl[QUOT_BITS-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      nxt.r = DW'(t - {1'b0, d});
      nxt.q = {cur.q[QUOT_BITS-2:0], 1'b1};
    end else begin
      nxt.r = DW'(t);
      nxt.q = {cur.q[QUOT_BITS-2:0], 1'b0};
    end
    return nxt;
  endfunction

  always_comb begin
    rdy[NS-1] = !v[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end
  assign in_ready = rdy[0];

  // quotient needs more than 32 bits exactly when N >= D * 2^32
  assign dshift = LW'(dmag) << QUOT_BITS;

  always_comb begin
    entry          = '0;
    entry.rx       = DW'(nmag_x >> QUOT_BITS);
    entry.ry       = DW'(nmag_y >> QUOT_BITS);
    entry.nlx      = QUOT_BITS'(nmag_x);
    entry.nly      = QUOT_BITS'(nmag_y);
    entry.d        = dmag;
    entry.fl       = flags_in;
    entry.fl.ovf_x = LW'(nmag_x) >= dshift;
    entry.fl.ovf_y = LW'(nmag_y) >= dshift;
    entry.crd      = crd_in;
  end

  always_comb begin
    for (int k = 0; k < NS - 1; k++) begin
      lx[k] = div_step('{r: st[k].rx, nl: st[k].nlx, q: st[k].qx}, st[k].d);
      ly[k] = div_step('{r: st[k].ry, nl: st[k].nly, q: st[k].qy}, st[k].d);
    end
  end

  always_comb begin
    st_next[0] = entry;
    for (int k = 1; k < NS; k++) begin
      st_next[k]     = st[k-1];
      st_next[k].rx  = lx[k-1].r;
      st_next[k].nlx = lx[k-1].nl;
      st_next[k].qx  = lx[k-1].q;
      st_next[k].ry  = ly[k-1].r;
      st_next[k].nly = ly[k-1].nl;
      st_next[k].qy  = ly[k-1].q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NS; k++) v[k] <= 1'b0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) st[0] <= st_next[0];
    for (int k = 1; k < NS; k++) begin
      if (rdy[k] && v[k-1]) st[k] <= st_next[k];
    end
  end

  assign out_valid = v[NS-1];
  assign qmag_x    = st[NS-1].qx;
  assign qmag_y    = st[NS-1].qy;
  assign flags     = st[NS-1].fl;
  assign crd       = st[NS-1].crd;

endmodule

// ===== rtl/core/sgi_back.sv =====
// ----------------------------------------------------------------------------
// sgi_back
// Signs and saturation of the quotients, then the bounding range test;
// the second stage is the output register.
// ----------------------------------------------------------------------------
module sgi_back import sgi_pkg::*; #(
  parameter int W = COORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [QUOT_BITS-1:0] qmag_x,
  input  logic [QUOT_BITS-1:0] qmag_y,
  input  sgi_flags_t           flags,
  input  logic [8*W-1:0]       crd_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sgi_out_t             res
);

  logic v1, v2, r1, r2;
  logic signed [RES_BITS-1:0] x1, y1, xs, ys;
  logic                       par1;
  logic [8*W-1:0]             crd1;
  logic signed [RES_BITS-1:0] cw [NUM_COORDS];
  logic                       hit;
  sgi_out_t                   res_q;

  function automatic logic signed [RES_BITS-1:0] sat_q(logic [QUOT_BITS-1:0] qm,
                                                        logic neg, logic ovf);
    logic signed [RES_BITS-1:0] r;
    if (ovf) begin
      r = neg ? RES_MIN : RES_MAX;
    end else if (neg) begin
      r = (qm > QUOT_BITS'(RES_MIN)) ? RES_MIN : RES_BITS'(-qm);
    end else begin
      r = qm[QUOT_BITS-1] ? RES_MAX : RES_BITS'(qm);
    end
    return r;
  endfunction

  function automatic logic in_range(logic signed [RES_BITS-1:0] c,
                                    logic signed [RES_BITS-1:0] e1,
                                    logic signed [RES_BITS-1:0] e2);
    logic signed [RES_BITS-1:0] lo, hi;
    lo = (e1 < e2) ? e1 : e2;
    hi = (e1 < e2) ? e2 : e1;
    return (lo <= c) && (c <= hi);
  endfunction

  assign r2 = !v2 || out_ready;
  assign r1 = !v1 || r2;
  assign in_ready = r1;

  assign xs = sat_q(qmag_x, flags.neg_x, flags.ovf_x);
  assign ys = sat_q(qmag_y, flags.neg_y, flags.ovf_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      x1   <= flags.par ? '0 : xs;
      y1   <= flags.par ? '0 : ys;
      par1 <= flags.par;
      crd1 <= crd_in;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_COORDS; k++) begin
      cw[k] = RES_BITS'($signed(crd1[k*W +: W]));
    end
  end

  assign hit = !par1 && in_range(x1, cw[0], cw[2]) && in_range(x1, cw[4], cw[6]) &&
               in_range(y1, cw[1], cw[3]) && in_range(y1, cw[5], cw[7]);

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      res_q.lines_cross  <= !par1;
      res_q.segments_hit <= hit;
      res_q.cross_x      <= x1;
      res_q.cross_y      <= y1;
    end
  end

  assign out_valid = v2;
  assign res       = res_q;

endmodule

// ===== rtl/core/segment_intersection_unit.sv =====
// ----------------------------------------------------------------------------
// segment_intersection_unit
// Crossing point of two integer line segments by Cramer's rule, fully
// pipelined, with exact truncating division and 32-bit saturation.
// ----------------------------------------------------------------------------
//   channel  signals                      payload
//   input    pair_valid / pair_ready      pair : sgi_in_t  (two segments)
//   output   res_valid  / res_ready       res  : sgi_out_t (flags, point)
//
// one segment pair per cycle while res_ready is held high; 5 equation stages,
// 33 divider stages and 2 saturation and bounds stages, with one quotient
// bit per stage of the divider.
// synchronous reset clears all stage valid bits; the data path has no reset.
// each stage holds its item when the next one is full and stalled, so
// bubbles fill in behind a stalled output and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module segment_intersection_unit import sgi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     pair_valid,
  output logic     pair_ready,
  input  sgi_in_t  pair,
  output logic     res_valid,
  input  logic     res_ready,
  output sgi_out_t res
);

  localparam int W = COORD_BITS;

  logic                 f_valid, f_ready;
  logic [3*W+3:0]       f_nmag_x, f_nmag_y;
  logic [2*W+2:0]       f_dmag;
  sgi_flags_t           f_flags;
  logic [8*W-1:0]       f_crd;

  logic                 d_valid, d_ready;
  logic [QUOT_BITS-1:0] d_qmag_x, d_qmag_y;
  sgi_flags_t           d_flags;
  logic [8*W-1:0]       d_crd;

  sgi_front #(.W(W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pair_valid),
    .in_ready  (pair_ready),
    .pair      (pair),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .nmag_x    (f_nmag_x),
    .nmag_y    (f_nmag_y),
    .dmag      (f_dmag),
    .flags     (f_flags),
    .crd       (f_crd)
  );

  sgi_div #(.W(W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .nmag_x    (f_nmag_x),
    .nmag_y    (f_nmag_y),
    .dmag      (f_dmag),
    .flags_in  (f_flags),
    .crd_in    (f_crd),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .qmag_x    (d_qmag_x),
    .qmag_y    (d_qmag_y),
    .flags     (d_flags),
    .crd       (d_crd)
  );

  sgi_back #(.W(W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .qmag_x    (d_qmag_x),
    .qmag_y    (d_qmag_y),
    .flags     (d_flags),
    .crd_in    (d_crd),
    .out_valid (res_valid),
    .out_ready (res_ready),
    .res       (res)
  );

`ifndef SYNTH
  a_parallel_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.lines_cross |->
      res.cross_x == '0 && res.cross_y == '0 && !res.segments_hit)
    else $error("parallel result carries a nonzero point or a hit");

  a_hit_needs_cross: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.segments_hit |-> res.lines_cross)
    else $error("hit reported without a crossing");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.segments_hit |->
      res.cross_x >= -(RES_BITS'(1) <<< (W - 1)) &&
      res.cross_x <= (RES_BITS'(1) <<< (W - 1)) - 1 &&
      res.cross_y >= -(RES_BITS'(1) <<< (W - 1)) &&
      res.cross_y <= (RES_BITS'(1) <<< (W - 1)) - 1)
    else $error("hit point outside the coordinate range");
`endif

endmodule
